>>> rtl/spd_pkg.sv
// Package with the shared constants and types of the shortest path block.
`default_nettype none
package spd_pkg;
  localparam int unsigned NODES = 16;
  localparam int unsigned EDGES = 64;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned NIDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EIDX_W = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int unsigned ECNT_W = $clog2(EDGES + 1);
  localparam int unsigned DIST_W = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  // Edge memory word: start, end, cost, both-ways flag.
  localparam int unsigned EDGE_W = 2 * NIDX_W + WEIGHT_BITS + 1;
  localparam int unsigned IN_W = 32;
  localparam int unsigned OUT_W = 32;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DIST   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              last;
  } result_t;
endpackage
`default_nettype wire

>>> rtl/spd_ram.sv
// Generic simple dual-port synchronous RAM (one write port, one read port) with a registered read.
`default_nettype none
module spd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/shortest_path_distances.sv
// Top level of the shortest path block: edge table, distance memory and sequencer.
//
// Input words on s_axis carry an operation. An edge add is answered by one
// status word the cycle after it is taken. A run word makes the block walk
// Dijkstra's algorithm; a run word with a source out of range is answered
// by one range status word instead. The seed state writes the source
// distance as zero. Each round then scans all nodes in the distance memory
// to pick the nearest unsettled node. It then walks the edge table, with as
// many read-modify-write relaxations of the distance memory as each edge
// needs. A run has up to NODES+1 rounds. The output phase steps through all
// nodes and sends one word per seen node, the last one with tlast.
// Input is taken only while no item is in work. After an edge add, the next
// input waits until its status word is taken.
// Reset clears the edge count, the seen bits and the sequencer; the
// memories hold no reset value. When the receiver stalls, the held output
// word stays stable and the sequencer waits.
`default_nettype none
module shortest_path_distances (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: node_a[5:0], node_b[11:6], weight[27:12], both_ways[28], zeros.
  input  wire logic [31:0] s_axis_tdata,
  // tuser: op.
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: node[5:0], distance[29:6], reachable[30], zero.
  output logic [31:0]      m_axis_tdata,
  // tuser: status.
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  localparam int unsigned NW = spd_pkg::NIDX_W;
  localparam int unsigned EW = spd_pkg::EIDX_W;
  localparam int unsigned DW = spd_pkg::DIST_W;
  localparam int unsigned NN = spd_pkg::NODES;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_INIT, S_SCAN, S_SCANW, S_EDGE, S_RELAX_RD, S_RELAX_WR,
    S_OUT_RD, S_OUT_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [spd_pkg::ECNT_W-1:0] etot_q;
  logic [spd_pkg::NODES-1:0] seen_q, settled_q, reached_q;
  logic [NW:0] cnt_q;
  logic [spd_pkg::ECNT_W-1:0] ecnt_q;
  logic [NW-1:0] pick_q;
  logic pick_ok_q;
  logic [DW-1:0] pick_d_q, base_q;
  logic [NW-1:0] tgt_q;
  logic [DW-1:0] cand_q;
  logic side_q;
  logic out_v_q;
  spd_pkg::result_t res_q;

  // Memory ports.
  logic e_we;
  logic [EW-1:0] e_raddr;
  logic [spd_pkg::EDGE_W-1:0] e_rdata, e_wdata;
  logic d_we;
  logic [NW-1:0] d_addr, d_waddr;
  logic [DW-1:0] d_wdata, d_rdata;

  logic in_ok;
  logic [5:0] in_a, in_b;
  assign in_a = s_axis_tdata[5:0];
  assign in_b = s_axis_tdata[11:6];
  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign in_ok = s_axis_tvalid && s_axis_tready;

  logic a_rng, b_rng;
  assign a_rng = {26'd0, in_a} < 32'(spd_pkg::NODES);
  assign b_rng = {26'd0, in_b} < 32'(spd_pkg::NODES);

  // One-hot node masks of the input word.
  logic [NN-1:0] a_bit, b_bit;
  assign a_bit = NN'(1) << in_a[NW-1:0];
  assign b_bit = NN'(1) << in_b[NW-1:0];

  assign e_we = in_ok && (s_axis_tuser == spd_pkg::OP_ADD) && a_rng && b_rng
                && (etot_q != spd_pkg::ECNT_W'(spd_pkg::EDGES));
  assign e_wdata = {in_a[NW-1:0], in_b[NW-1:0],
                    s_axis_tdata[12 +: spd_pkg::WEIGHT_BITS], s_axis_tdata[28]};
  assign e_raddr = ecnt_q[EW-1:0];

  // Status of an edge add: range check first, then the full check.
  logic [1:0] add_st;
  assign add_st = !(a_rng && b_rng) ? spd_pkg::ST_RANGE :
                  (!e_we ? spd_pkg::ST_FULL : spd_pkg::ST_STORED);

  spd_ram #(.WIDTH(spd_pkg::EDGE_W), .DEPTH(spd_pkg::EDGES)) u_edges (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(etot_q[EW-1:0]), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  spd_ram #(.WIDTH(DW), .DEPTH(spd_pkg::NODES)) u_dist (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_addr), .rdata_o(d_rdata)
  );

  // Decoded edge fields from the registered read.
  logic [NW-1:0] ed_a, ed_b;
  logic [spd_pkg::WEIGHT_BITS-1:0] ed_w;
  logic ed_bi;
  assign {ed_a, ed_b, ed_w, ed_bi} = e_rdata;

  // Relaxation candidate, saturated.
  logic [DW:0] sum;
  assign sum = {1'b0, base_q} + (DW+1)'(ed_w);

  logic [NW-1:0] prev_n;
  assign prev_n = NW'(cnt_q - 1'b1);

  // Memory address and write control.
  always_comb begin
    d_we = 1'b0;
    d_waddr = tgt_q;
    d_wdata = cand_q;
    d_addr = cnt_q[NW-1:0];
    case (state_q)
      S_SEED: begin
        d_we = 1'b1;
        d_waddr = pick_q;
        d_wdata = '0;
      end
      S_RELAX_RD: d_addr = tgt_q;
      S_RELAX_WR: d_we = !reached_q[tgt_q] || (cand_q < d_rdata);
      S_OUT_WAIT: d_addr = prev_n;
      S_OUT: d_addr = prev_n;
      default: ;
    endcase
  end

  // Last seen node check for the output phase.
  logic more_seen;
  always_comb begin
    more_seen = 1'b0;
    for (int i = 0; i < spd_pkg::NODES; i++) begin
      if ((i > int'(prev_n)) && seen_q[i]) more_seen = 1'b1;
    end
  end

  // A new output word is loaded in this cycle.
  logic out_set;
  assign out_set = ((state_q == S_IDLE) && in_ok &&
                    ((s_axis_tuser == spd_pkg::OP_ADD) || !a_rng)) ||
                   ((state_q == S_OUT) && (!out_v_q || m_axis_tready));

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      etot_q <= '0;
      seen_q <= '0;
      settled_q <= '0;
      reached_q <= '0;
      out_v_q <= 1'b0;
      cnt_q <= '0;
      ecnt_q <= '0;
      pick_ok_q <= 1'b0;
    end else begin
      out_v_q <= out_set || (out_v_q && !m_axis_tready);
      case (state_q)
        S_IDLE: begin
          if (in_ok) begin
            if (s_axis_tuser == spd_pkg::OP_ADD) begin
              res_q <= '{status: add_st, node: '0, distance: '0,
                         reachable: 1'b0, last: 1'b1};
              if (e_we) begin
                etot_q <= etot_q + 1'b1;
                seen_q <= seen_q | a_bit | b_bit;
              end
            end else if (!a_rng) begin
              res_q <= '{status: spd_pkg::ST_RANGE, node: '0, distance: '0,
                         reachable: 1'b0, last: 1'b1};
            end else begin
              seen_q <= seen_q | a_bit;
              pick_q <= in_a[NW-1:0];
              settled_q <= '0;
              reached_q <= a_bit;
              state_q <= S_SEED;
            end
          end
        end
        // The source distance is written as zero.
        S_SEED: state_q <= S_INIT;
        S_INIT: begin
          cnt_q <= '0;
          pick_ok_q <= 1'b0;
          state_q <= S_SCAN;
        end
        // Scan: address cnt issued, data of cnt-1 returns.
        S_SCAN: begin
          if (cnt_q != '0) begin
            if (reached_q[prev_n] && !settled_q[prev_n] &&
                (!pick_ok_q || d_rdata < pick_d_q)) begin
              pick_ok_q <= 1'b1;
              pick_q <= prev_n;
              pick_d_q <= d_rdata;
            end
          end
          if (cnt_q == (NW+1)'(spd_pkg::NODES)) state_q <= S_SCANW;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_SCANW: begin
          if (!pick_ok_q) begin
            cnt_q <= '0;
            state_q <= S_OUT_RD;
          end else begin
            settled_q[pick_q] <= 1'b1;
            base_q <= pick_d_q;
            ecnt_q <= '0;
            side_q <= 1'b0;
            state_q <= (etot_q == '0) ? S_INIT : S_OUT_WAIT;
          end
        end
        // Edge read data is valid; check the current side.
        S_EDGE: begin
          cand_q <= sum[DW] ? spd_pkg::DIST_MAX : sum[DW-1:0];
          if (!side_q && ed_a == pick_q && !settled_q[ed_b]) begin
            tgt_q <= ed_b;
            state_q <= S_RELAX_RD;
          end else if (ed_bi && ed_b == pick_q && !settled_q[ed_a] &&
                       (side_q || !(ed_a == pick_q))) begin
            side_q <= 1'b1;
            tgt_q <= ed_a;
            state_q <= S_RELAX_RD;
          end else if (!side_q && ed_bi && ed_b == pick_q) begin
            side_q <= 1'b1;
          end else begin
            side_q <= 1'b0;
            if (ecnt_q + 1'b1 == etot_q) state_q <= S_INIT;
            else begin
              ecnt_q <= ecnt_q + 1'b1;
              state_q <= S_OUT_WAIT;
            end
          end
        end
        S_RELAX_RD: state_q <= S_RELAX_WR;
        // Write back if better; then move to the next side or edge.
        S_RELAX_WR: begin
          if (d_we) reached_q[tgt_q] <= 1'b1;
          if (!side_q && ed_bi && ed_b == pick_q) begin
            side_q <= 1'b1;
            state_q <= S_EDGE;
          end else begin
            side_q <= 1'b0;
            if (ecnt_q + 1'b1 == etot_q) state_q <= S_INIT;
            else begin
              ecnt_q <= ecnt_q + 1'b1;
              state_q <= S_OUT_WAIT;
            end
          end
        end
        // Output phase or edge read wait, shared state.
        S_OUT_WAIT: state_q <= (pick_ok_q) ? S_EDGE : S_OUT;
        S_OUT_RD: begin
          if (cnt_q == (NW+1)'(spd_pkg::NODES)) state_q <= S_IDLE;
          else if (!seen_q[cnt_q[NW-1:0]]) cnt_q <= cnt_q + 1'b1;
          else begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_OUT_WAIT;
          end
        end
        S_OUT: begin
          if (!out_v_q || m_axis_tready) begin
            res_q <= '{status: spd_pkg::ST_DIST,
                       node: spd_pkg::NODE_W'(prev_n),
                       distance: reached_q[prev_n] ? d_rdata : spd_pkg::DIST_MAX,
                       reachable: reached_q[prev_n],
                       last: !more_seen};
            state_q <= S_OUT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser = res_q.status;
  assign m_axis_tlast = res_q.last;
  assign m_axis_tdata = {1'b0, res_q.reachable, res_q.distance, res_q.node};

  // The edge count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    etot_q <= spd_pkg::ECNT_W'(spd_pkg::EDGES)) else $error("edge count overflow");
  // No input is taken while a word waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !s_axis_tready) else $error("ready with pending word");
  // Settled nodes are always reached.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled_q & ~reached_q) == '0) else $error("settled but unreached");
endmodule
`default_nettype wire

>>> tb/shortest_path_distances_tb.sv
// Self-checking testbench for the shortest path block: edge loads, runs and status words.
`default_nettype none
module shortest_path_distances_tb;

  typedef struct packed {
    logic       op;
    logic [5:0] node_a;
    logic [5:0] node_b;
    logic [15:0] weight;
    logic       both_ways;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  shortest_path_distances i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow graph and expected words.
  logic [5:0]  g_from [spd_pkg::EDGES];
  logic [5:0]  g_to [spd_pkg::EDGES];
  logic [15:0] g_cost [spd_pkg::EDGES];
  logic        g_bi [spd_pkg::EDGES];
  int unsigned g_count;
  logic [spd_pkg::NODES-1:0] g_seen;
  spd_pkg::result_t expected_words[$];
  cmd_t pending_cmds[$];
  int errors = 0;
  int n_runs = 0, n_adds = 0, n_words = 0;
  bit drain_req = 1'b0;   // sender pauses until everything came back
  bit hold_req = 1'b0;    // receiver holds off for a long stretch
  bit stim_done = 1'b0;

  function automatic void push_word(logic [1:0] st, logic [5:0] nd, logic [23:0] d,
                                    logic r, logic l);
    spd_pkg::result_t w;
    w.status = st; w.node = nd; w.distance = d; w.reachable = r; w.last = l;
    expected_words = {expected_words, w};
  endfunction

  function automatic void queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  // Predict the words that one accepted command causes.
  function automatic void predict_cmd(cmd_t c);
    logic [23:0] dist_v [spd_pkg::NODES];
    bit reached [spd_pkg::NODES];
    bit settled [spd_pkg::NODES];
    int pick, k;
    longint cand;
    int unsigned lastn;
    if (c.op == spd_pkg::OP_ADD) begin
      if (c.node_a >= spd_pkg::NODES || c.node_b >= spd_pkg::NODES)
        push_word(spd_pkg::ST_RANGE, 0, 0, 0, 1);
      else if (g_count >= spd_pkg::EDGES) push_word(spd_pkg::ST_FULL, 0, 0, 0, 1);
      else begin
        g_from[g_count] = c.node_a; g_to[g_count] = c.node_b;
        g_cost[g_count] = c.weight; g_bi[g_count] = c.both_ways;
        g_count++;
        g_seen[c.node_a] = 1'b1; g_seen[c.node_b] = 1'b1;
        push_word(spd_pkg::ST_STORED, 0, 0, 0, 1);
      end
      return;
    end
    if (c.node_a >= spd_pkg::NODES) begin
      push_word(spd_pkg::ST_RANGE, 0, 0, 0, 1);
      return;
    end
    g_seen[c.node_a] = 1'b1;
    for (int i = 0; i < spd_pkg::NODES; i++) begin
      dist_v[i] = spd_pkg::DIST_MAX; reached[i] = 0; settled[i] = 0;
    end
    dist_v[c.node_a] = 0; reached[c.node_a] = 1;
    forever begin
      pick = -1;
      for (int i = 0; i < spd_pkg::NODES; i++)
        if (reached[i] && !settled[i] && (pick < 0 || dist_v[i] < dist_v[pick])) pick = i;
      if (pick < 0) break;
      settled[pick] = 1;
      for (int e = 0; e < g_count; e++) begin
        for (int dir = 0; dir < 2; dir++) begin
          if (dir == 0 && g_from[e] != pick) continue;
          if (dir == 1 && !(g_bi[e] && g_to[e] == pick)) continue;
          k = (dir == 0) ? g_to[e] : g_from[e];
          cand = longint'(dist_v[pick]) + g_cost[e];
          if (cand > spd_pkg::DIST_MAX) cand = spd_pkg::DIST_MAX;
          if (!settled[k] && (!reached[k] || cand < dist_v[k])) begin
            reached[k] = 1; dist_v[k] = cand[23:0];
          end
        end
      end
    end
    for (int i = 0; i < spd_pkg::NODES; i++) if (g_seen[i]) lastn = i;
    for (int i = 0; i < spd_pkg::NODES; i++)
      if (g_seen[i])
        push_word(spd_pkg::ST_DIST, 6'(i), reached[i] ? dist_v[i] : spd_pkg::DIST_MAX,
                  reached[i], i == lastn);
  endfunction

  function automatic cmd_t mk(logic op, logic [5:0] a, logic [5:0] b, logic [15:0] w,
                              logic bi);
    cmd_t c;
    c.op = op; c.node_a = a; c.node_b = b; c.weight = w; c.both_ways = bi;
    return c;
  endfunction

  // Stimulus: directed part, then random commands with runs.
  initial begin
    cmd_t c;
    queue_cmd(mk(spd_pkg::OP_RUN, 5, 0, 0, 0));          // lone source
    queue_cmd(mk(spd_pkg::OP_RUN, 63, 63, 16'hffff, 1)); // bad source
    queue_cmd(mk(spd_pkg::OP_ADD, 16, 0, 1, 0));         // range on start
    queue_cmd(mk(spd_pkg::OP_ADD, 0, 63, 1, 1));         // range on end
    queue_cmd(mk(spd_pkg::OP_ADD, 0, 1, 16'hffff, 0));
    queue_cmd(mk(spd_pkg::OP_ADD, 1, 2, 0, 1));
    queue_cmd(mk(spd_pkg::OP_ADD, 3, 15, 7, 0));         // 3 only as target start
    queue_cmd(mk(spd_pkg::OP_ADD, 2, 2, 9, 1));          // self loop
    queue_cmd(mk(spd_pkg::OP_RUN, 0, 0, 0, 0));
    queue_cmd(mk(spd_pkg::OP_RUN, 2, 0, 0, 0));
    queue_cmd(mk(spd_pkg::OP_RUN, 15, 0, 0, 0));         // target-only node
    queue_cmd(mk(spd_pkg::OP_RUN, 16, 5, 3, 1));
    // Long chain of heavy edges for large distances.
    for (int i = 4; i < 14; i++)
      queue_cmd(mk(spd_pkg::OP_ADD, 6'(i), 6'(i + 1), 16'hffff, 1));
    for (int i = 0; i < 250; i++) queue_cmd(mk(spd_pkg::OP_ADD, 4, 5, 16'hffff, 0));
    queue_cmd(mk(spd_pkg::OP_RUN, 14, 0, 0, 0));
    queue_cmd(mk(spd_pkg::OP_ADD, 1, 1, 1, 1));          // table full
    queue_cmd(mk(spd_pkg::OP_RUN, 4, 0, 0, 0));
    // Trim the fill loop: only enough adds to pass the full mark.
    pending_cmds = pending_cmds[0:21];
    for (int i = 0; i < 52; i++) queue_cmd(mk(spd_pkg::OP_ADD, 4, 5, 16'hffff, 0));
    queue_cmd(mk(spd_pkg::OP_ADD, 1, 1, 1, 1));
    queue_cmd(mk(spd_pkg::OP_RUN, 14, 0, 0, 0));
    queue_cmd(mk(spd_pkg::OP_RUN, 4, 0, 0, 0));
    wait (rst_ni);
    wait (pending_cmds.size() == 0 && expected_words.size() == 0);
    // Fresh tables need a reset; instead keep going on the full table with runs,
    // then random content still exercises adds as full/range responses.
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) queue_cmd(mk(spd_pkg::OP_RUN, 6'(i), 0, 0, 0));
    wait (pending_cmds.size() == 0);
    drain_req = 1'b1;
    wait (expected_words.size() == 0);
    drain_req = 1'b0;
    for (int i = 0; i < 150; i++) begin
      c.op = 1'($urandom);
      c.node_a = 6'($urandom);
      c.node_b = 6'($urandom);
      c.weight = 16'($urandom);
      c.both_ways = 1'($urandom);
      if ($urandom_range(0, 3) != 0) c.node_a = 6'($urandom_range(0, spd_pkg::NODES - 1));
      if ($urandom_range(0, 3) != 0) c.node_b = 6'($urandom_range(0, spd_pkg::NODES - 1));
      queue_cmd(c);
    end
    wait (pending_cmds.size() == 0);
    stim_done = 1'b1;
  end

  // Driver: one command per handshake, random gap before each.
  int send_gap = 0;
  int n_offered = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && (n_adds + n_runs != n_offered)) begin
        // The offered word has not been taken yet.
      end else if (drain_req || pending_cmds.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_cmds[0].op;
        s_axis_tdata <= {3'b0, pending_cmds[0].both_ways, pending_cmds[0].weight,
                         pending_cmds[0].node_b, pending_cmds[0].node_a};
        n_offered <= n_offered + 1;
        send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      end
    end
  end

  // Accept side of the driver, and the receiver's ready.
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_cmd(pending_cmds.pop_front());
      if (s_axis_tuser == spd_pkg::OP_RUN) n_runs++; else n_adds++;
    end
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= 3000;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready)
          recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      end
    end
  end

  // Monitor: compare each output word with the oldest expectation.
  always @(posedge clk_i) begin
    spd_pkg::result_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_words++;
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tuser != w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[5:0] != w.node) begin
          $error("node: expected %0d, got %0d", w.node, m_axis_tdata[5:0]); errors++;
        end
        if (m_axis_tdata[29:6] != w.distance) begin
          $error("distance: expected %0d, got %0d", w.distance, m_axis_tdata[29:6]);
          errors++;
        end
        if (m_axis_tdata[30] != w.reachable) begin
          $error("reachable: expected %0d, got %0d", w.reachable, m_axis_tdata[30]);
          errors++;
        end
        if (m_axis_tlast != w.last) begin
          $error("last: expected %0d, got %0d", w.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any handshake.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reset, then wait for the end of the run.
  initial begin
    g_count = 0;
    g_seen = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (stim_done && expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d edge adds and %0d runs; checked %0d output words.",
             n_adds, n_runs, n_words);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/spd_pkg.sv
rtl/spd_ram.sv
rtl/shortest_path_distances.sv
tb/shortest_path_distances_tb.sv
